[src/occ_pkg.sv]
`timescale 1ns / 1ps
// shared types and constants for the occlusion cover culler
// no dependencies
package occ_pkg;

  localparam int COVER_ENTRIES_DEF = 64;
  localparam int COORD_W = 24;

  typedef logic [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t t;
    coord_t b;
    coord_t l;
    coord_t r;
  } entry_t;

  typedef struct packed {
    logic   func;
    coord_t rect_left;
    coord_t rect_top;
    coord_t rect_right;
    coord_t rect_bottom;
  } rect_t;

  typedef struct packed {
    logic        visible;
    logic [31:0] shown_total;
    logic [31:0] hidden_total;
    logic [6:0]  peak_entries;
    logic        overflow;
  } res_t;

  typedef struct packed {
    logic pop;
    logic push;
  } chain_ctl_t;

  localparam logic FUNC_TEST  = 1'b0;
  localparam logic FUNC_CLEAR = 1'b1;

endpackage

[src/occ_cell.sv]
`timescale 1ns / 1ps
// one cell of the cover chain: holds a single row interval entry
// depends on occ_pkg
module occ_cell #(
  parameter int IDX   = 0,
  parameter int DEPTH = 2
) (
  input  logic                      clk,
  input  occ_pkg::chain_ctl_t       ctl,
  input  logic [$clog2(DEPTH)-1:0]  wr_idx,
  input  occ_pkg::entry_t           piece,
  input  occ_pkg::entry_t           nxt,
  output occ_pkg::entry_t           q
);
  import occ_pkg::*;

  localparam int IW = $clog2(DEPTH);
  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  always_ff @(posedge clk) begin
    if (ctl.push && wr_idx == MY_IDX) begin
      q <= piece;
    end else if (ctl.pop) begin
      q <= nxt;
    end
  end

endmodule

[src/occlusion_cover_culler.sv]
`timescale 1ns / 1ps
// occlusion cover culler top level: sequencer plus the cover cell chain
// depends on occ_pkg and occ_cell
//
// usage: rectangles come in on the rect channel (rect_valid / rect_stall), one
// result beat per rectangle leaves on the res channel (res_valid / res_stall).
// func clear empties the cover table and zeroes the counters; its result is
// all zeros. one item is worked at a time: the cover entries sit in a chain of
// cells that shifts toward cell 0, the sequencer takes entries from the head
// and writes new pieces behind them. an item takes a trim and test pass over
// the held entries (at most COVER_ENTRIES) and, when shown, a rebuild pass
// that writes the pieces produced from each entry (at most three per entry)
// and a closing piece, then the result is loaded into the output register.
// the chain has twice COVER_ENTRIES cells so old and rebuilt entries fit side
// by side. rect_stall is high while an item is in work. the result sits in an
// output register; a stalled res beat holds, and the next rectangle is still
// taken and worked while it waits. reset empties the table and zeroes the counters.
module occlusion_cover_culler #(
  parameter int COVER_ENTRIES = occ_pkg::COVER_ENTRIES_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           rect_valid,
  output logic           rect_stall,
  input  occ_pkg::rect_t rect,
  output logic           res_valid,
  input  logic           res_stall,
  output occ_pkg::res_t  res
);
  import occ_pkg::*;

  localparam int DEPTH = 2 * COVER_ENTRIES;
  localparam int OW    = $clog2(DEPTH + 1);
  localparam int IW    = $clog2(DEPTH);
  localparam int CW    = $clog2(COVER_ENTRIES + 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(COVER_ENTRIES);

  typedef enum logic [2:0] {ST_IDLE, ST_TRIM, ST_BUILD, ST_FIN} state_t;

  state_t          state;
  logic [OW-1:0]   occ;
  logic [CW-1:0]   rem;
  logic [CW-1:0]   kept;
  logic [CW-1:0]   ncount;
  logic [CW-1:0]   peak;
  logic            full;
  logic            covered;
  logic            clr;
  logic            trun;
  logic [24:0]     start;
  logic [24:0]     cur;
  entry_t          hold;
  logic            hold_v;
  logic [1:0]      ph;
  logic [31:0]     shown;
  logic [31:0]     hidden;
  rect_t           cr;

  entry_t          cell_q [DEPTH];
  entry_t          head;
  chain_ctl_t      ctl;
  logic [IW-1:0]   wr_idx;
  entry_t          piece;

  coord_t          lft, top, rgt, bot;
  logic            above, contains;
  logic [3:0]      sv;
  entry_t          sp [4];
  logic [1:0]      sel;
  logic            any_v, more;
  logic [24:0]     cur_after;
  logic            want_push;
  logic [31:0]     shown_next, hidden_next;
  logic [CW-1:0]   peak_next;
  logic [CW+6:0]   peak_wide;

  assign head = cell_q[0];
  assign lft  = cr.rect_left;
  assign top  = cr.rect_top;
  assign rgt  = cr.rect_right;
  assign bot  = cr.rect_bottom;
  assign rect_stall = (state != ST_IDLE);

  // pieces produced from the held entry
  always_comb begin
    above    = hold.t > bot;
    contains = (hold.l <= lft) && (hold.r >= rgt);
    sv = 4'b0000;
    for (int k = 0; k < 4; k++) sp[k] = hold;
    if (above) begin
      sv[0] = cur <= {1'b0, bot};
      sp[0] = '{t: cur[23:0], b: bot, l: lft, r: rgt};
      sv[2] = 1'b1;
      cur_after = sv[0] ? ({1'b0, bot} + 25'd1) : cur;
    end else begin
      sv[0] = {1'b0, hold.t} > cur;
      sp[0] = '{t: cur[23:0], b: hold.t - 24'd1, l: lft, r: rgt};
      sv[2] = 1'b1;
      if (!contains) begin
        sv[1] = hold.t < top;
        sp[1] = '{t: hold.t, b: top - 24'd1, l: hold.l, r: hold.r};
        sp[2] = '{t: (hold.t > top) ? hold.t : top,
                  b: (hold.b < bot) ? hold.b : bot, l: lft, r: rgt};
        sv[3] = hold.b > bot;
        sp[3] = '{t: bot + 24'd1, b: hold.b, l: hold.l, r: hold.r};
      end
      cur_after = (({1'b0, hold.b} + 25'd1) > cur) ? ({1'b0, hold.b} + 25'd1) : cur;
    end
    any_v = 1'b0;
    sel   = 2'd0;
    for (int k = 3; k >= 0; k--) begin
      if (sv[k] && 2'(k) >= ph) begin
        any_v = 1'b1;
        sel   = 2'(k);
      end
    end
    more = 1'b0;
    for (int k = 0; k < 4; k++) begin
      if (sv[k] && 2'(k) > sel) more = 1'b1;
    end
  end

  // chain control
  always_comb begin
    ctl       = '{pop: 1'b0, push: 1'b0};
    want_push = 1'b0;
    piece     = head;
    wr_idx    = IW'(occ);
    unique case (state)
      ST_TRIM: begin
        if (rem != '0) begin
          ctl.pop  = 1'b1;
          ctl.push = head.b >= top;
          wr_idx   = IW'(occ - OW'(1));
        end
      end
      ST_BUILD: begin
        if (!hold_v) begin
          if (rem != '0) begin
            ctl.pop = 1'b1;
          end else begin
            want_push = cur <= {1'b0, bot};
            piece     = '{t: cur[23:0], b: bot, l: lft, r: rgt};
          end
        end else begin
          want_push = any_v;
          piece     = sp[sel];
        end
        ctl.push = want_push && (ncount != CNT_MAX);
      end
      default: ;
    endcase
  end

  // result values
  always_comb begin
    shown_next  = shown;
    hidden_next = hidden;
    peak_next   = peak;
    if (!clr) begin
      if (covered) begin
        hidden_next = (hidden == 32'hFFFF_FFFF) ? hidden : hidden + 32'd1;
      end else begin
        shown_next = (shown == 32'hFFFF_FFFF) ? shown : shown + 32'd1;
        if (ncount > peak) peak_next = ncount;
      end
    end
    peak_wide = {7'd0, peak_next};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      occ       <= '0;
      shown     <= '0;
      hidden    <= '0;
      peak      <= '0;
      res_valid <= 1'b0;
      hold_v    <= 1'b0;
    end else begin
      if (state == ST_FIN && (!res_valid || !res_stall)) begin
        res_valid <= 1'b1;
      end else if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (rect_valid) begin
            cr <= rect;
            if (rect.func == FUNC_CLEAR) begin
              occ     <= '0;
              shown   <= '0;
              hidden  <= '0;
              peak    <= '0;
              clr     <= 1'b1;
              covered <= 1'b1;
              full    <= 1'b0;
              state   <= ST_FIN;
            end else begin
              clr     <= 1'b0;
              rem     <= CW'(occ);
              kept    <= '0;
              covered <= rect.rect_bottom < rect.rect_top;
              trun    <= rect.rect_bottom >= rect.rect_top;
              start   <= {1'b0, rect.rect_top};
              state   <= ST_TRIM;
            end
          end
        end
        ST_TRIM: begin
          if (rem != '0) begin
            rem <= rem - CW'(1);
            if (head.b >= top) begin
              kept <= kept + CW'(1);
              if (trun) begin
                if ({1'b0, head.t} > start || head.l > lft || head.r < rgt) begin
                  trun <= 1'b0;
                end else begin
                  start <= {1'b0, head.b} + 25'd1;
                  if (({1'b0, head.b} + 25'd1) > {1'b0, bot}) begin
                    covered <= 1'b1;
                    trun    <= 1'b0;
                  end
                end
              end
            end else begin
              occ <= occ - OW'(1);
            end
          end else if (covered) begin
            state <= ST_FIN;
          end else begin
            rem    <= kept;
            cur    <= {1'b0, top};
            ncount <= '0;
            full   <= 1'b0;
            hold_v <= 1'b0;
            state  <= ST_BUILD;
          end
        end
        ST_BUILD: begin
          if (ctl.pop) occ <= occ - OW'(1);
          if (ctl.push) begin
            occ    <= occ + OW'(1);
            ncount <= ncount + CW'(1);
          end
          if (want_push && ncount == CNT_MAX) full <= 1'b1;
          if (!hold_v) begin
            if (rem != '0) begin
              hold   <= head;
              hold_v <= 1'b1;
              ph     <= 2'd0;
              rem    <= rem - CW'(1);
            end else begin
              state <= ST_FIN;
            end
          end else begin
            ph <= sel + 2'd1;
            if (!any_v || !more) begin
              hold_v <= 1'b0;
              cur    <= cur_after;
            end
          end
        end
        ST_FIN: begin
          if (!res_valid || !res_stall) begin
            shown     <= shown_next;
            hidden    <= hidden_next;
            peak      <= peak_next;
            res       <= '{visible: !covered, shown_total: shown_next,
                           hidden_total: hidden_next, peak_entries: peak_wide[6:0],
                           overflow: !covered && full};
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t nxt;
    if (i < DEPTH - 1) begin : g_mid
      assign nxt = cell_q[i+1];
    end else begin : g_end
      assign nxt = '0;
    end
    occ_cell #(
      .IDX   (i),
      .DEPTH (DEPTH)
    ) u_cell (
      .clk    (clk),
      .ctl    (ctl),
      .wr_idx (wr_idx),
      .piece  (piece),
      .nxt    (nxt),
      .q      (cell_q[i])
    );
  end

endmodule

[tb/sv/occlusion_cover_culler_tb.sv]
`timescale 1ns / 1ps
// self-checking testbench for occlusion_cover_culler: directed table then random rectangles
// depends on occ_pkg and the occlusion_cover_culler rtl
module occlusion_cover_culler_tb;
  import occ_pkg::*;

  localparam int NENT = 64;
  localparam int N_RANDOM = 2000;
  localparam int WATCHDOG = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic rect_valid = 1'b0;
  logic rect_stall;
  rect_t rect = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  res_t res;

  always #1 clk = ~clk;

  occlusion_cover_culler dut (
    .clk(clk), .rst(rst), .rect_valid(rect_valid), .rect_stall(rect_stall), .rect(rect),
    .res_valid(res_valid), .res_stall(res_stall), .res(res)
  );

  // predictor state
  entry_t cov[NENT];
  int cov_n;
  logic [31:0] shown_cnt, hidden_cnt;
  logic [6:0] peak_cnt;
  entry_t pieces[NENT];
  int piece_n;
  bit piece_full;

  res_t results_due[$];
  int mismatches = 0;
  bit hold_long = 0;
  int idle_cycles = 0;

  function automatic void cull_clear();
    cov_n = 0;
    shown_cnt = '0;
    hidden_cnt = '0;
    peak_cnt = '0;
  endfunction

  function automatic void add_piece(logic [24:0] t, logic [24:0] b, coord_t l, coord_t r);
    if (piece_n >= NENT) begin
      piece_full = 1;
    end else begin
      pieces[piece_n] = '{t: t[23:0], b: b[23:0], l: l, r: r};
      piece_n++;
    end
  endfunction

  function automatic res_t cull_predict(rect_t x);
    res_t o;
    int kept;
    bit hid;
    logic [24:0] start, cur;
    entry_t e;
    o = '0;
    if (x.func == FUNC_CLEAR) begin
      cull_clear();
      return o;
    end
    kept = 0;
    for (int i = 0; i < cov_n; i++) begin
      if (cov[i].b >= x.rect_top) begin
        cov[kept] = cov[i];
        kept++;
      end
    end
    cov_n = kept;
    hid = 0;
    if (x.rect_bottom < x.rect_top) begin
      hid = 1;
    end else begin
      start = {1'b0, x.rect_top};
      for (int i = 0; i < cov_n; i++) begin
        if ({1'b0, cov[i].t} > start) break;
        if (cov[i].l > x.rect_left || cov[i].r < x.rect_right) break;
        start = {1'b0, cov[i].b} + 25'd1;
        if (start > {1'b0, x.rect_bottom}) begin
          hid = 1;
          break;
        end
      end
    end
    if (hid) begin
      if (hidden_cnt != 32'hFFFF_FFFF) hidden_cnt++;
    end else begin
      cur = {1'b0, x.rect_top};
      piece_n = 0;
      piece_full = 0;
      for (int i = 0; i < cov_n; i++) begin
        e = cov[i];
        if (e.t > x.rect_bottom) begin
          if (cur <= {1'b0, x.rect_bottom}) begin
            add_piece(cur, {1'b0, x.rect_bottom}, x.rect_left, x.rect_right);
            cur = {1'b0, x.rect_bottom} + 25'd1;
          end
          add_piece({1'b0, e.t}, {1'b0, e.b}, e.l, e.r);
          continue;
        end
        if ({1'b0, e.t} > cur)
          add_piece(cur, {1'b0, e.t} - 25'd1, x.rect_left, x.rect_right);
        if (e.l <= x.rect_left && e.r >= x.rect_right) begin
          add_piece({1'b0, e.t}, {1'b0, e.b}, e.l, e.r);
        end else begin
          if (e.t < x.rect_top)
            add_piece({1'b0, e.t}, {1'b0, x.rect_top} - 25'd1, e.l, e.r);
          add_piece({1'b0, (e.t > x.rect_top) ? e.t : x.rect_top},
                    {1'b0, (e.b < x.rect_bottom) ? e.b : x.rect_bottom},
                    x.rect_left, x.rect_right);
          if (e.b > x.rect_bottom)
            add_piece({1'b0, x.rect_bottom} + 25'd1, {1'b0, e.b}, e.l, e.r);
        end
        if ({1'b0, e.b} + 25'd1 > cur) cur = {1'b0, e.b} + 25'd1;
      end
      if (cur <= {1'b0, x.rect_bottom})
        add_piece(cur, {1'b0, x.rect_bottom}, x.rect_left, x.rect_right);
      for (int i = 0; i < piece_n; i++) cov[i] = pieces[i];
      cov_n = piece_n;
      o.overflow = piece_full;
      if (shown_cnt != 32'hFFFF_FFFF) shown_cnt++;
      if (cov_n > peak_cnt) peak_cnt = 7'(cov_n);
    end
    o.visible = !hid;
    o.shown_total = shown_cnt;
    o.hidden_total = hidden_cnt;
    o.peak_entries = peak_cnt;
    return o;
  endfunction

  // directed rows; chk marks a typed-in expectation
  typedef struct {
    rect_t r;
    bit chk;
    res_t want;
  } row_t;

  row_t rows[$];
  coord_t top_now;

  function automatic rect_t mk(logic f, coord_t l, coord_t t, coord_t r, coord_t b);
    rect_t x;
    x.func = f;
    x.rect_left = l;
    x.rect_top = t;
    x.rect_right = r;
    x.rect_bottom = b;
    return x;
  endfunction

  function automatic void add_row(rect_t x, bit c, res_t w);
    row_t rw;
    rw.r = x;
    rw.chk = c;
    rw.want = w;
    rows.push_back(rw);
  endfunction

  task automatic send(rect_t x);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      rect_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rect_valid <= 1'b1;
    rect <= x;
    @(posedge clk);
    while (rect_stall) @(posedge clk);
    results_due.push_back(cull_predict(x));
  endtask

  task automatic send_row(row_t rw);
    int gap;
    gap = $urandom_range(0, 3);
    if (gap > 0) begin
      rect_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rect_valid <= 1'b1;
    rect <= rw.r;
    @(posedge clk);
    while (rect_stall) @(posedge clk);
    if (rw.chk) begin
      void'(cull_predict(rw.r));
      results_due.push_back(rw.want);
    end else begin
      results_due.push_back(cull_predict(rw.r));
    end
  endtask

  function automatic rect_t rand_rect();
    rect_t x;
    int k;
    coord_t h, w;
    k = $urandom_range(0, 99);
    x.func = FUNC_TEST;
    if (k < 2) begin
      x = mk(FUNC_CLEAR, coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
             coord_t'($urandom));
      top_now = '0;
      return x;
    end
    if (k < 5) begin
      x.rect_left = coord_t'($urandom);
      x.rect_right = coord_t'($urandom);
      x.rect_top = coord_t'($urandom);
      x.rect_bottom = coord_t'($urandom);
      return x;
    end
    if (top_now > 24'hFFF000 || $urandom_range(0, 199) == 0) begin
      x = mk(FUNC_CLEAR, '0, '0, '0, '0);
      top_now = '0;
      return x;
    end
    top_now = top_now + coord_t'($urandom_range(0, 3) == 0 ? $urandom_range(0, 40) : 0);
    h = coord_t'($urandom_range(0, 30));
    w = coord_t'($urandom_range(0, 60));
    x.rect_top = top_now;
    x.rect_bottom = (k < 8) ? top_now - 1 : top_now + h;
    if (k < 10) x.rect_bottom = 24'hFFFFFF;
    x.rect_left = ($urandom_range(0, 9) == 0) ? coord_t'($urandom) :
                  coord_t'($urandom_range(24'h7FFF00, 24'h7FFF80));
    x.rect_right = (k < 12) ? x.rect_left - 1 : x.rect_left + w;
    if ($urandom_range(0, 49) == 0) x.rect_right = 24'hFFFFFF;
    return x;
  endfunction

  // result checker
  always @(posedge clk) begin
    res_t want;
    if (!rst && res_valid && !res_stall) begin
      if (results_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", res);
      end else begin
        want = results_due.pop_front();
        if (res !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: vis %b/%b shown %0d/%0d hidden %0d/%0d peak %0d/%0d ovf %b/%b",
                     want.visible, res.visible, want.shown_total, res.shown_total,
                     want.hidden_total, res.hidden_total, want.peak_entries,
                     res.peak_entries, want.overflow, res.overflow);
        end
      end
    end
  end

  // receiver stalls
  initial begin
    int gap;
    @(negedge rst);
    forever begin
      if (hold_long) begin
        res_stall <= 1'b1;
        repeat (400) @(posedge clk);
        hold_long = 0;
      end
      gap = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
      if ($urandom_range(0, 2) == 0) gap = 0;
      res_stall <= (gap != 0);
      repeat (gap > 0 ? gap : 1) @(posedge clk);
      res_stall <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((rect_valid && !rect_stall) || (res_valid && !res_stall) || rst)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("occlusion_cover_culler_tb NOT OK");
      $finish;
    end
  end

  initial begin
    res_t z;
    rect_t x;
    z = '0;
    cull_clear();
    top_now = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    add_row(mk(FUNC_TEST, 24'd10, 24'd0, 24'd20, 24'd5), 1,
            '{visible: 1, shown_total: 1, hidden_total: 0, peak_entries: 1, overflow: 0});
    add_row(mk(FUNC_TEST, 24'd12, 24'd0, 24'd18, 24'd3), 1,
            '{visible: 0, shown_total: 1, hidden_total: 1, peak_entries: 1, overflow: 0});
    add_row(mk(FUNC_TEST, 24'd0, 24'd2, 24'd30, 24'd8), 0, z);
    add_row(mk(FUNC_TEST, 24'd5, 24'd4, 24'd25, 24'd3), 0, z);
    add_row(mk(FUNC_TEST, 24'd40, 24'd4, 24'd30, 24'd6), 0, z);
    add_row(mk(FUNC_TEST, 24'd0, 24'd12, 24'd4, 24'd14), 0, z);
    add_row(mk(FUNC_TEST, 24'd2, 24'd13, 24'd3, 24'd13), 0, z);
    add_row(mk(FUNC_TEST, 24'd0, 24'd20, 24'hFFFFFF, 24'd30), 0, z);
    add_row(mk(FUNC_TEST, 24'hFFFFFF, 24'd25, 24'd0, 24'd26), 0, z);
    add_row(mk(FUNC_TEST, 24'd7, 24'd31, 24'd7, 24'd31), 0, z);
    add_row(mk(FUNC_CLEAR, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF), 1, z);
    add_row(mk(FUNC_TEST, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF), 1,
            '{visible: 1, shown_total: 1, hidden_total: 0, peak_entries: 1, overflow: 0});
    add_row(mk(FUNC_TEST, 24'd0, 24'hFFFFFF, 24'd0, 24'd0), 0, z);
    add_row(mk(FUNC_CLEAR, 24'd0, 24'd0, 24'd0, 24'd0), 1, z);
    // send the same one-row strip 66 times; all but the first are hidden
    for (int i = 0; i < 66; i++)
      add_row(mk(FUNC_TEST, 24'd0, 24'd0, 24'd0, 24'd0), 0, z);
    foreach (rows[i]) send_row(rows[i]);
    rows.delete();
    for (int i = 0; i < 70; i++) begin
      x = mk(FUNC_TEST, coord_t'(i & 1), coord_t'(0), coord_t'(1 + (i & 1)), coord_t'(0));
      x.rect_top = (i < 64) ? 24'd0 : 24'd0;
      x.rect_bottom = coord_t'(200 - 2 * i);
      x.rect_top = coord_t'(200 - 2 * i);
      x.rect_top = 24'd0 + ((i == 0) ? 24'd0 : 24'd0);
      x.rect_top = 24'd0;
      x.rect_bottom = 24'd0;
      x.rect_left = coord_t'(i);
      x.rect_right = coord_t'(i);
      x.rect_top = 24'd0;
      x.rect_bottom = coord_t'(i);
      send(x);
    end
    send(mk(FUNC_CLEAR, 24'd0, 24'd0, 24'd0, 24'd0));
    for (int i = 0; i < 66; i++)
      send(mk(FUNC_TEST, 24'd0, 24'd0, 24'd0, coord_t'(2 * i)) | '0);

    // long receiver hold while the sender keeps offering
    hold_long = 1;
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM / 2) begin
        rect_valid <= 1'b0;
        while (results_due.size() != 0) @(posedge clk);
      end
      x = rand_rect();
      if (x.func == FUNC_CLEAR) top_now = '0;
      send(x);
    end
    rect_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (500) @(posedge clk);
    if (mismatches == 0 && results_due.size() == 0)
      $display("occlusion_cover_culler_tb OK");
    else
      $display("occlusion_cover_culler_tb NOT OK");
    $finish;
  end
endmodule
